// ===== src/sht_pkg.sv =====
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types, character codes and keyword table of the highlight tokenizer.
// ----------------------------------------------------------------------------
package sht_pkg;

    localparam int unsigned MAX_TOKEN = 1023;
    localparam int unsigned CNT_W     = 10;
    localparam int unsigned CHAR_W    = 16;
    localparam int unsigned KW_COUNT  = 47;
    localparam int unsigned KW_BYTES  = 7;

    localparam logic [CNT_W-1:0] MAX_LEN   = CNT_W'(MAX_TOKEN);
    localparam logic [CNT_W-1:0] DEPTH_CAP = {CNT_W{1'b1}};

    // Scanner modes
    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_STR      = 4'd1,
        MODE_CHR      = 4'd2,
        MODE_LINE     = 4'd3,
        MODE_BRACE    = 4'd4,
        MODE_WORD     = 4'd5,
        MODE_NUM      = 4'd6,
        MODE_NUM_E    = 4'd7,
        MODE_NUM_TAIL = 4'd8
    } scan_mode_t;

    // Token classes as reported on the result stream
    typedef enum logic [3:0] {
        CLS_OPERATOR      = 4'd0,
        CLS_STRING        = 4'd1,
        CLS_CHAR          = 4'd2,
        CLS_LINE_COMMENT  = 4'd3,
        CLS_BLOCK_COMMENT = 4'd4,
        CLS_GLOBAL        = 4'd5,
        CLS_RESERVED      = 4'd6,
        CLS_IDENT         = 4'd7,
        CLS_NUMBER        = 4'd8
    } token_class_t;

    typedef struct packed {
        token_class_t     cls;
        logic [CNT_W-1:0] len;
    } result_t;

    // Up to two results caused by one request
    typedef struct packed {
        logic    two;
        result_t first_res;
        result_t second_res;
    } entry_t;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_HASH   = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_APOS   = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 16'h002B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_DIG_0  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_DIG_9  = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 16'h003B;
    localparam logic [CHAR_W-1:0] CH_AT     = 16'h0040;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_F   = 16'h0046;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 16'h005A;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 16'h005F;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LO_B   = 16'h0062;
    localparam logic [CHAR_W-1:0] CH_LO_E   = 16'h0065;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 16'h007A;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;

    // Reserved words, right-justified, zero padded on the left
    localparam logic [KW_BYTES*8-1:0] KW_TABLE [KW_COUNT] = '{
        "alias", "assert", "bit16", "bit32", "bit64", "bit8", "block", "bool",
        "break", "case", "catch", "char", "class", "const", "dbg", "default",
        "dict", "do", "elif", "else", "end", "enum", "false", "finally",
        "float", "for", "foreach", "func", "if", "ifdef", "inf", "int",
        "list", "me", "null", "queue", "ret", "rls", "skip", "stack",
        "switch", "throw", "to", "true", "try", "var", "while"
    };

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               c == CH_UNDER || c == CH_AT || c == CH_BSLASH;
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_DIG_0 && c <= CH_DIG_9;
    endfunction

    // Number of characters in keyword k
    function automatic logic [3:0] kw_len(input int unsigned k);
        logic [KW_BYTES*8-1:0] w;
        logic [3:0]            n;
        w = KW_TABLE[k];
        n = 4'd0;
        for (int b = 0; b < KW_BYTES; b++) begin
            if (w[b*8 +: 8] != 8'h00) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // Character idx of keyword k, zero past its end
    function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] idx);
        logic [KW_BYTES*8-1:0] w;
        logic [3:0]            n;
        logic [7:0]            ch;
        w  = KW_TABLE[k];
        n  = kw_len(k);
        ch = 8'h00;
        if ({1'b0, idx} < n) begin
            ch = w[(int'(n) - 1 - int'(idx)) * 8 +: 8];
        end
        return ch;
    endfunction

endpackage

// ===== src/sht_scanner.sv =====
// ----------------------------------------------------------------------------
// sht_scanner
// Scanner state and per-character classification; builds the result entry
// for each accepted request in the same cycle.
// ----------------------------------------------------------------------------
module sht_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    input  logic [sht_pkg::CHAR_W-1:0]    char_code,
    input  logic                          line_end,
    output logic                          push,
    output sht_pkg::entry_t               push_entry
);
    import sht_pkg::*;

    scan_mode_t        mode_reg,  mode_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic              at_reg,    at_next;
    logic [KW_COUNT-1:0] match_reg, match_next;

    logic [CNT_W-1:0]  cnt1;
    logic              at_limit;
    logic              reserved;
    token_class_t      pend_cls;

    // start decode
    scan_mode_t        st_mode;
    logic [CNT_W-1:0]  st_count;
    logic [CNT_W-1:0]  st_depth;
    logic              st_at;
    logic              st_op;
    logic [KW_COUNT-1:0] st_match;

    // main step
    logic              fl_valid;
    result_t           fl_res;
    logic              do_grow;
    scan_mode_t        grow_mode;
    token_class_t      grow_cls;
    logic              go_idle;
    logic              use_start;
    logic [CNT_W-1:0]  d_new;
    logic              op_valid;
    result_t           op_res;

    assign cnt1     = count_reg + 1'b1;
    assign at_limit = (cnt1 >= MAX_LEN);

    // Reserved-word test from the running match vector
    always_comb begin
        reserved = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (match_reg[k] && count_reg == {{(CNT_W-4){1'b0}}, kw_len(k)}) begin
                reserved = 1'b1;
            end
        end
        if (count_reg == '0 || count_reg > CNT_W'(KW_BYTES)) begin
            reserved = 1'b0;
        end
    end

    // Class of the open token
    always_comb begin
        case (mode_reg)
            MODE_STR:   pend_cls = CLS_STRING;
            MODE_CHR:   pend_cls = CLS_CHAR;
            MODE_LINE:  pend_cls = CLS_LINE_COMMENT;
            MODE_BRACE: pend_cls = CLS_BLOCK_COMMENT;
            MODE_WORD:  pend_cls = at_reg ? CLS_GLOBAL : (reserved ? CLS_RESERVED : CLS_IDENT);
            default:    pend_cls = CLS_NUMBER;
        endcase
    end

    // Decode a character that opens a new token
    always_comb begin
        st_mode  = MODE_IDLE;
        st_count = CNT_W'(1);
        st_depth = '0;
        st_at    = 1'b0;
        st_op    = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            st_match[k] = (char_code == {8'h00, kw_char(k, 3'd0)});
        end
        if (char_code == CH_QUOTE) begin
            st_mode = MODE_STR;
        end else if (char_code == CH_APOS) begin
            st_mode = MODE_CHR;
        end else if (char_code == CH_SEMI) begin
            st_mode = MODE_LINE;
        end else if (char_code == CH_LBRACE) begin
            st_mode  = MODE_BRACE;
            st_depth = CNT_W'(1);
        end else if (is_letter(char_code)) begin
            st_mode = MODE_WORD;
            st_at   = (char_code == CH_AT);
        end else if (is_digit(char_code)) begin
            st_mode = MODE_NUM;
        end else begin
            st_op    = 1'b1;
            st_count = '0;
        end
    end

    // Advance the scanner by one character or end of line
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        depth_next = depth_reg;
        at_next    = at_reg;
        match_next = match_reg;
        fl_valid   = 1'b0;
        fl_res     = '{cls: pend_cls, len: count_reg};
        do_grow    = 1'b0;
        grow_mode  = mode_reg;
        grow_cls   = pend_cls;
        go_idle    = 1'b0;
        use_start  = 1'b0;
        d_new      = depth_reg;

        if (item_valid) begin
            if (line_end) begin
                fl_valid = (mode_reg != MODE_IDLE);
                go_idle  = 1'b1;
            end else begin
                case (mode_reg)
                    MODE_STR, MODE_CHR: begin
                        if (char_code == ((mode_reg == MODE_STR) ? CH_QUOTE : CH_APOS)) begin
                            fl_valid   = 1'b1;
                            fl_res.len = cnt1;
                            go_idle    = 1'b1;
                        end else begin
                            do_grow = 1'b1;
                        end
                    end
                    MODE_LINE: begin
                        do_grow = 1'b1;
                    end
                    MODE_BRACE: begin
                        if (char_code == CH_LBRACE && depth_reg < DEPTH_CAP) begin
                            d_new = depth_reg + 1'b1;
                        end else if (char_code == CH_RBRACE && depth_reg != '0) begin
                            d_new = depth_reg - 1'b1;
                        end
                        if (d_new == '0 || at_limit) begin
                            fl_valid   = 1'b1;
                            fl_res.len = cnt1;
                            go_idle    = 1'b1;
                        end else begin
                            depth_next = d_new;
                            count_next = cnt1;
                        end
                    end
                    MODE_WORD: begin
                        if (is_letter(char_code) || is_digit(char_code)) begin
                            if (count_reg < CNT_W'(8)) begin
                                for (int k = 0; k < KW_COUNT; k++) begin
                                    match_next[k] = match_reg[k] &&
                                        (char_code == {8'h00, kw_char(k, count_reg[2:0])});
                                end
                            end
                            at_next  = at_reg | (char_code == CH_AT);
                            grow_cls = at_next ? CLS_GLOBAL : CLS_IDENT;
                            do_grow  = 1'b1;
                        end else begin
                            fl_valid  = 1'b1;
                            use_start = 1'b1;
                        end
                    end
                    MODE_NUM: begin
                        do_grow = 1'b1;
                        if (is_digit(char_code) || (char_code >= CH_UP_A && char_code <= CH_UP_F) ||
                            char_code == CH_HASH || char_code == CH_DOT) begin
                            grow_mode = MODE_NUM;
                        end else if (char_code == CH_LO_E) begin
                            grow_mode = MODE_NUM_E;
                        end else if (char_code == CH_LO_B) begin
                            grow_mode = MODE_NUM_TAIL;
                        end else begin
                            do_grow   = 1'b0;
                            fl_valid  = 1'b1;
                            use_start = 1'b1;
                        end
                    end
                    MODE_NUM_E: begin
                        if (char_code == CH_PLUS || char_code == CH_MINUS) begin
                            do_grow   = 1'b1;
                            grow_mode = MODE_NUM_TAIL;
                        end else begin
                            fl_valid  = 1'b1;
                            use_start = 1'b1;
                        end
                    end
                    MODE_NUM_TAIL: begin
                        if (is_digit(char_code)) begin
                            do_grow = 1'b1;
                        end else begin
                            fl_valid  = 1'b1;
                            use_start = 1'b1;
                        end
                    end
                    default: begin
                        use_start = 1'b1;
                    end
                endcase
            end
        end

        // Extend the token, or close it at the length cap
        if (do_grow) begin
            if (at_limit) begin
                fl_valid = 1'b1;
                fl_res   = '{cls: grow_cls, len: cnt1};
                go_idle  = 1'b1;
            end else begin
                mode_next  = grow_mode;
                count_next = cnt1;
            end
        end

        if (go_idle) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            depth_next = '0;
            at_next    = 1'b0;
        end

        if (use_start) begin
            mode_next  = st_mode;
            count_next = st_count;
            depth_next = st_depth;
            at_next    = st_at;
            match_next = st_match;
        end
    end

    // Pack the results of this request
    assign op_valid = use_start & st_op;
    assign op_res   = '{cls: CLS_OPERATOR, len: CNT_W'(1)};
    assign push     = fl_valid | op_valid;

    always_comb begin
        push_entry.two        = fl_valid & op_valid;
        push_entry.first_res  = fl_valid ? fl_res : op_res;
        push_entry.second_res = op_res;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            depth_reg <= '0;
            at_reg    <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            depth_reg <= depth_next;
            at_reg    <= at_next;
        end
    end

    // Keyword match vector, only read while a word is open
    always_ff @(posedge aclk) begin
        match_reg <= match_next;
    end

endmodule

// ===== src/sht_result_queue.sv =====
// ----------------------------------------------------------------------------
// sht_result_queue
// Two-entry result buffer; each entry holds the one or two results of one
// request and is sent out as one or two beats.
// ----------------------------------------------------------------------------
module sht_result_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  sht_pkg::entry_t        push_entry,
    output logic                   space,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [3:0] token_class, [13:4] token_length
    output logic                   m_tlast
);
    import sht_pkg::*;

    entry_t      entries_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg,   fill_next;
    logic        beat_reg,   beat_next;

    entry_t      head;
    result_t     cur;
    logic        pop_beat;
    logic        pop_item;

    assign head     = entries_reg[rd_ptr_reg];
    assign cur      = beat_reg ? head.second_res : head.first_res;
    assign m_tvalid = (fill_reg != 2'd0);
    assign m_tdata  = {2'b00, cur.len, cur.cls};
    assign m_tlast  = ~head.two | beat_reg;
    assign space    = (fill_reg != 2'd2);

    assign pop_beat = m_tvalid & m_tready;
    assign pop_item = pop_beat & m_tlast;

    // Advance pointers, fill level and beat select
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop_item;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop_item};
        beat_next   = pop_beat ? ~m_tlast : beat_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            beat_reg   <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            beat_reg   <= beat_next;
        end
    end

    // Store an entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/syntax_highlight_tokenizer.sv =====
// ----------------------------------------------------------------------------
// syntax_highlight_tokenizer
// Splits a stream of source characters into highlight tokens (class, length).
// ----------------------------------------------------------------------------
// Input stream: one request per source character, s_tdata = UTF-16 code;
// s_tuser = 1 marks end of line (character ignored, open token flushed,
// scanner returned to idle).
// Result stream: one beat per token, m_tdata = class and length, m_tlast set
// on the final result caused by one request. A request causes zero, one or
// two results (a closed token followed by a one-character operator).
// A result is registered in the two-entry result buffer when the request
// that causes it is accepted, and is presented on m_tvalid from there.
// Throughput: one character per cycle while each request causes at most one
// result and m_tready stays high; a request with two results is sent as two
// beats over the single result port. A two-entry result buffer sits between
// scanner and output, so s_tready stays high while one finished entry waits.
// Stall: when m_tready is low the buffer fills; s_tready falls once both
// entries are occupied and rises as soon as one is sent.
// Reset: aresetn (synchronous, active low) empties the buffer and leaves
// the scanner idle with no token open.
// ----------------------------------------------------------------------------
module syntax_highlight_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] char_code
    input  logic        s_tuser,   // [0] line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] token_class, [13:4] token_length
    output logic        m_tlast
);
    import sht_pkg::*;

    logic   accept;
    logic   push;
    entry_t push_entry;

    assign accept = s_tvalid & s_tready;

    // Scan one character per accepted request
    sht_scanner u_scanner (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (accept),
        .char_code  (s_tdata),
        .line_end   (s_tuser),
        .push       (push),
        .push_entry (push_entry)
    );

    // Buffer results and drive the output stream
    sht_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .space      (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // Results are only produced by an accepted request
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> accept)
        else $error("result entry pushed without an accepted request");

    // End of line never yields an operator after the flushed token
    a_eol_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_tuser) |-> !push_entry.two)
        else $error("end of line produced two results");

    // Every token covers at least one character
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (push_entry.first_res.len != '0 && push_entry.second_res.len != '0))
        else $error("token of zero length");

    // The second result of a pair follows the first one
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("second result of a pair missing");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the highlight tokenizer. Feeds directed lines,
// one token past the length cap and random well-formed lines with noise.
// Both stream sides stall at random. A scoreboard predicts every token and
// compares it with the result stream.
// ----------------------------------------------------------------------------
module tb;
    import sht_pkg::*;

    localparam logic [9:0]  TOKEN_CAP   = 10'd1023;
    localparam logic [15:0] CH_SPACE    = 16'h0020;
    localparam int          STALL_LIMIT = 4000;
    localparam int          ITEM_BUDGET = 1400;

    typedef struct {
        token_class_t cls;
        logic [9:0]   len;
        logic         last;
    } hl_token_t;

    // Scanner copy and store of the tokens still due on the result stream
    class token_checker;
        scan_mode_t  mode;
        logic [9:0]  run_len;
        logic [9:0]  nest;
        logic        has_at;
        logic [15:0] word_buf [8];
        string       reserved [47];
        hl_token_t   tokens_due [$];
        int          errors;
        int          checked;
        int          per_class [9];

        function new();
            mode    = MODE_IDLE;
            run_len = '0;
            nest    = '0;
            has_at  = 1'b0;
            foreach (word_buf[i]) word_buf[i] = '0;
            foreach (per_class[i]) per_class[i] = 0;
            errors  = 0;
            checked = 0;
            reserved = '{
                "alias", "assert", "bit16", "bit32", "bit64", "bit8", "block", "bool",
                "break", "case", "catch", "char", "class", "const", "dbg", "default",
                "dict", "do", "elif", "else", "end", "enum", "false", "finally",
                "float", "for", "foreach", "func", "if", "ifdef", "inf", "int",
                "list", "me", "null", "queue", "ret", "rls", "skip", "stack",
                "switch", "throw", "to", "true", "try", "var", "while"
            };
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function bit word_char(input logic [15:0] c);
            return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                   c == CH_UNDER || c == CH_AT || c == CH_BSLASH;
        endfunction

        function bit digit_char(input logic [15:0] c);
            return c >= CH_DIG_0 && c <= CH_DIG_9;
        endfunction

        function void push_token(input token_class_t cls, input logic [9:0] len);
            hl_token_t t;
            t.cls  = cls;
            t.len  = len;
            t.last = 1'b0;
            tokens_due.push_back(t);
        endfunction

        // Report the open token, if any, and return to idle
        function void close_token();
            token_class_t cls;
            string        w;
            bit           keyword;
            if (mode != MODE_IDLE) begin
                case (mode)
                    MODE_STR:   cls = CLS_STRING;
                    MODE_CHR:   cls = CLS_CHAR;
                    MODE_LINE:  cls = CLS_LINE_COMMENT;
                    MODE_BRACE: cls = CLS_BLOCK_COMMENT;
                    MODE_WORD: begin
                        keyword = 1'b0;
                        if (run_len >= 10'd1 && run_len <= 10'd7) begin
                            keyword = 1'b1;
                            w = "";
                            for (int i = 0; i < int'(run_len); i++) begin
                                if (word_buf[i][15:8] != 8'h00) keyword = 1'b0;
                                w = {w, " "};
                                w.putc(i, word_buf[i][7:0]);
                            end
                            if (keyword) begin
                                keyword = 1'b0;
                                foreach (reserved[k]) begin
                                    if (reserved[k] == w) keyword = 1'b1;
                                end
                            end
                        end
                        cls = has_at ? CLS_GLOBAL : (keyword ? CLS_RESERVED : CLS_IDENT);
                    end
                    default:    cls = CLS_NUMBER;
                endcase
                push_token(cls, run_len);
            end
            mode    = MODE_IDLE;
            run_len = '0;
            nest    = '0;
            has_at  = 1'b0;
        endfunction

        // Count one more character; report the token once it hits the cap
        function void extend(input scan_mode_t next);
            run_len = run_len + 10'd1;
            if (run_len >= TOKEN_CAP) close_token();
            else mode = next;
        endfunction

        // Begin a token on character c, or report it as an operator
        function void open_token(input logic [15:0] c);
            run_len = 10'd1;
            nest    = '0;
            has_at  = 1'b0;
            if (c == CH_QUOTE) begin
                mode = MODE_STR;
            end else if (c == CH_APOS) begin
                mode = MODE_CHR;
            end else if (c == CH_SEMI) begin
                mode = MODE_LINE;
            end else if (c == CH_LBRACE) begin
                mode = MODE_BRACE;
                nest = 10'd1;
            end else if (word_char(c)) begin
                mode        = MODE_WORD;
                word_buf[0] = c;
                has_at      = (c == CH_AT);
            end else if (digit_char(c)) begin
                mode = MODE_NUM;
            end else begin
                push_token(CLS_OPERATOR, 10'd1);
                mode    = MODE_IDLE;
                run_len = '0;
            end
        endfunction

        // Predict the tokens caused by one accepted request
        function void note_char(input logic [15:0] c, input logic line_end);
            int        before_cnt;
            hl_token_t t;
            before_cnt = tokens_due.size();
            if (line_end) begin
                close_token();
            end else begin
                case (mode)
                    MODE_STR, MODE_CHR: begin
                        if (c == ((mode == MODE_STR) ? CH_QUOTE : CH_APOS)) begin
                            run_len = run_len + 10'd1;
                            close_token();
                        end else begin
                            extend(mode);
                        end
                    end
                    MODE_LINE: extend(MODE_LINE);
                    MODE_BRACE: begin
                        if (c == CH_LBRACE && nest < 10'd1023) nest = nest + 10'd1;
                        else if (c == CH_RBRACE && nest > 10'd0) nest = nest - 10'd1;
                        run_len = run_len + 10'd1;
                        if (nest == 10'd0 || run_len >= TOKEN_CAP) close_token();
                    end
                    MODE_WORD: begin
                        if (word_char(c) || digit_char(c)) begin
                            if (run_len < 10'd8) word_buf[run_len[2:0]] = c;
                            if (c == CH_AT) has_at = 1'b1;
                            extend(MODE_WORD);
                        end else begin
                            close_token();
                            open_token(c);
                        end
                    end
                    MODE_NUM: begin
                        if (digit_char(c) || (c >= CH_UP_A && c <= CH_UP_F) ||
                            c == CH_HASH || c == CH_DOT) begin
                            extend(MODE_NUM);
                        end else if (c == CH_LO_E) begin
                            extend(MODE_NUM_E);
                        end else if (c == CH_LO_B) begin
                            extend(MODE_NUM_TAIL);
                        end else begin
                            close_token();
                            open_token(c);
                        end
                    end
                    MODE_NUM_E: begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            extend(MODE_NUM_TAIL);
                        end else begin
                            close_token();
                            open_token(c);
                        end
                    end
                    MODE_NUM_TAIL: begin
                        if (digit_char(c)) begin
                            extend(MODE_NUM_TAIL);
                        end else begin
                            close_token();
                            open_token(c);
                        end
                    end
                    default: begin
                        mode = MODE_IDLE;
                        open_token(c);
                    end
                endcase
            end
            // Flag the final token of this request
            if (tokens_due.size() > before_cnt) begin
                t      = tokens_due.pop_back();
                t.last = 1'b1;
                tokens_due.push_back(t);
            end
        endfunction

        task report(input string what);
            errors++;
            if (errors <= 40) $display("mismatch %0d: %s", errors, what);
        endtask

        // Compare one accepted result with the oldest predicted token
        task check_token(input logic [15:0] data, input logic last_bit);
            hl_token_t want;
            if (tokens_due.size() == 0) begin
                report($sformatf("unexpected token class %0d length %0d",
                                 data[3:0], data[13:4]));
                return;
            end
            want = tokens_due.pop_front();
            checked++;
            per_class[want.cls]++;
            if (data[3:0] != want.cls)
                report($sformatf("token %0d class %0d, expected %0d",
                                 checked, data[3:0], want.cls));
            if (data[13:4] != want.len)
                report($sformatf("token %0d length %0d, expected %0d",
                                 checked, data[13:4], want.len));
            if (last_bit != want.last)
                report($sformatf("token %0d last %0b, expected %0b",
                                 checked, last_bit, want.last));
        endtask
    endclass

    typedef enum int {
        GEN_WORD,
        GEN_KEYWORD,
        GEN_NUMBER,
        GEN_STRING,
        GEN_CHAR,
        GEN_BRACE,
        GEN_OPERATOR,
        GEN_NOISE
    } gen_kind_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    logic        steady   = 1'b0;
    int          items_sent = 0;
    int          lines_sent = 0;
    int          quiet_cycles = 0;

    token_checker board = new();

    syntax_highlight_tokenizer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stall the result side at random, except in the steady stretch
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    // Sample both handshakes; predict, check and watch for a hang
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_char(s_tdata, s_tuser);
            if (m_tvalid && m_tready) board.check_token(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d tokens due",
                         quiet_cycles, board.pending());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Present one request after a random gap and hold it until accepted
    task automatic send_item(input logic [15:0] code, input logic line_end);
        while (!steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom());
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= line_end;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_char(input logic [15:0] code);
        send_item(code, 1'b0);
    endtask

    task automatic end_line();
        send_item(16'($urandom()), 1'b1);
        lines_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char({8'h00, s[i]});
    endtask

    // Hold off the sender until every predicted token has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
    endtask

    function automatic logic [15:0] rand_word_char(input bit lead);
        int r;
        r = $urandom_range(0, 19);
        if (r >= 17 && !lead) return CH_DIG_0 + 16'($urandom_range(0, 9));
        if (r < 9 || r >= 17) return CH_LO_A + 16'($urandom_range(0, 25));
        if (r < 14) return CH_UP_A + 16'($urandom_range(0, 25));
        if (r == 14) return CH_UNDER;
        if (r == 15) return CH_AT;
        return CH_BSLASH;
    endfunction

    function automatic logic [15:0] rand_other(input logic [15:0] avoid);
        logic [15:0] c;
        do begin
            if ($urandom_range(0, 3) == 0) c = 16'($urandom());
            else c = 16'($urandom_range(32, 126));
        end while (c == avoid);
        return c;
    endfunction

    // Send one token of the given kind with random content
    task automatic send_token(input gen_kind_t kind);
        string       ops;
        logic [15:0] c;
        logic [15:0] q;
        logic [55:0] kw;
        int          depth;
        int          n;
        ops = "+-*/=<>()[],.:!?&|^%~$#}";
        case (kind)
            GEN_WORD: begin
                send_char(rand_word_char(1'b1));
                repeat ($urandom_range(0, 10)) send_char(rand_word_char(1'b0));
            end
            GEN_KEYWORD: begin
                kw = KW_TABLE[$urandom_range(0, KW_COUNT - 1)];
                for (int b = 6; b >= 0; b--) begin
                    if (kw[b*8 +: 8] != 8'h00) send_char({8'h00, kw[b*8 +: 8]});
                end
                if ($urandom_range(0, 3) == 0) send_char(rand_word_char(1'b0));
            end
            GEN_NUMBER: begin
                send_char(CH_DIG_0 + 16'($urandom_range(0, 9)));
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 3))
                        0:       c = CH_DIG_0 + 16'($urandom_range(0, 9));
                        1:       c = CH_UP_A + 16'($urandom_range(0, 5));
                        2:       c = CH_HASH;
                        default: c = CH_DOT;
                    endcase
                    send_char(c);
                end
                case ($urandom_range(0, 4))
                    0: begin
                        send_char(CH_LO_E);
                        send_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                        repeat ($urandom_range(0, 3))
                            send_char(CH_DIG_0 + 16'($urandom_range(0, 9)));
                    end
                    1: begin
                        send_char(CH_LO_B);
                        repeat ($urandom_range(0, 3))
                            send_char(CH_DIG_0 + 16'($urandom_range(0, 9)));
                    end
                    2:       send_char(CH_LO_E);
                    default: ;
                endcase
            end
            GEN_STRING, GEN_CHAR: begin
                q = (kind == GEN_STRING) ? CH_QUOTE : CH_APOS;
                send_char(q);
                repeat ($urandom_range(0, 8)) send_char(rand_other(q));
                // leave a few open until the line ends
                if ($urandom_range(0, 6) != 0) send_char(q);
            end
            GEN_BRACE: begin
                depth = 1;
                send_char(CH_LBRACE);
                n = $urandom_range(0, 10);
                while (depth > 0 && n > 0) begin
                    case ($urandom_range(0, 3))
                        0:       c = CH_LBRACE;
                        1:       c = CH_RBRACE;
                        default: c = rand_other(CH_RBRACE);
                    endcase
                    if (c == CH_LBRACE) depth++;
                    if (c == CH_RBRACE) depth--;
                    send_char(c);
                    n--;
                end
                if ($urandom_range(0, 5) != 0) begin
                    while (depth > 0) begin
                        send_char(CH_RBRACE);
                        depth--;
                    end
                end
            end
            GEN_OPERATOR: send_char({8'h00, ops[$urandom_range(0, ops.len() - 1)]});
            default:      send_char(16'($urandom()));
        endcase
    endtask

    // Send one line: tokens with optional spaces and comment, or plain noise
    task automatic send_line();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 12))
                send_item(16'($urandom()), $urandom_range(0, 9) == 0);
        end else begin
            repeat ($urandom_range(1, 7)) begin
                send_token(gen_kind_t'($urandom_range(0, 7)));
                if ($urandom_range(0, 1) == 0) send_char(CH_SPACE);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_char(CH_SEMI);
                repeat ($urandom_range(0, 8)) send_char(rand_other(CH_SEMI));
            end
        end
        end_line();
    endtask

    // Send a token longer than the cap, then end the line
    task automatic send_long(input logic [15:0] opener, input int n);
        logic [15:0] c;
        send_char(opener);
        repeat (n - 1) begin
            case (opener)
                CH_SEMI:   c = 16'($urandom());
                CH_LBRACE: c = CH_LBRACE;
                CH_QUOTE:  c = rand_other(CH_QUOTE);
                default:   c = rand_word_char(1'b0);
            endcase
            send_char(c);
        end
        end_line();
    endtask

    initial begin
        int          line_no;
        logic [15:0] long_open;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: end of line while idle, code extremes, each class
        end_line();
        send_char(16'h0000);
        send_char(16'hFFFF);
        send_text("if;");
        end_line();
        send_text("\"s\"{{}}'c");
        end_line();
        send_text("@x 4e+ 3ez");
        end_line();
        drain();

        // One token that runs past the length cap, opener picked at random
        case ($urandom_range(0, 3))
            0:       long_open = CH_SEMI;
            1:       long_open = CH_LBRACE;
            2:       long_open = CH_QUOTE;
            default: long_open = CH_UNDER;
        endcase
        send_long(long_open, int'(TOKEN_CAP) + $urandom_range(1, 6));
        drain();

        // Random lines up to the item budget, with a steady stretch and drains
        line_no = 0;
        while (items_sent < ITEM_BUDGET) begin
            steady <= (line_no >= 4 && line_no < 12);
            if (line_no % 10 == 9) drain();
            send_line();
            line_no++;
        end
        steady <= 1'b0;
        drain();
        repeat (8) @(negedge aclk);

        $display("covered %0d requests over %0d lines, one token past the cap",
                 items_sent, lines_sent);
        $display("checked %0d tokens: op %0d str %0d chr %0d line %0d brace %0d %s",
                 board.checked, board.per_class[0], board.per_class[1],
                 board.per_class[2], board.per_class[3], board.per_class[4],
                 $sformatf("global %0d reserved %0d ident %0d number %0d",
                           board.per_class[5], board.per_class[6],
                           board.per_class[7], board.per_class[8]));
        if (board.errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
